// ===== sv/pfr_pkg.sv =====
// Shared types and constants for the packet filter and priority router.
// Used by the top level, the port checker and the testbench; depends on nothing.
package pfr_pkg;

	localparam int NUM_QUEUES = 3;
	localparam int QSEL_W     = 2;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 4;
	localparam int PORT_W     = 2;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIGH     = 4'd0,
		ST_MEDIUM   = 4'd1,
		ST_LOW      = 4'd2,
		ST_BAD_SRC  = 4'd3,
		ST_BAD_SUM  = 4'd4,
		ST_FULL     = 4'd5,
		ST_BAD_TYPE = 4'd6,
		ST_FORWARD  = 4'd7,
		ST_EMPTY    = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REJECT_SRC_LOW  = 3'd0,
		CFG_REJECT_SRC_HIGH = 3'd1,
		CFG_PORT1_DST_HIGH  = 3'd2,
		CFG_PORT2_DST_HIGH  = 3'd3,
		CFG_PORT3_DST_HIGH  = 3'd4
	} cfg_idx_t;

	localparam logic [DATA_W-1:0] RST_REJECT_SRC_LOW  = 32'd1753761824;
	localparam logic [DATA_W-1:0] RST_REJECT_SRC_HIGH = 32'd2000000000;
	localparam logic [DATA_W-1:0] RST_PORT1_DST_HIGH  = 32'd1073741823;
	localparam logic [DATA_W-1:0] RST_PORT2_DST_HIGH  = 32'd2147483647;
	localparam logic [DATA_W-1:0] RST_PORT3_DST_HIGH  = 32'd3221225472;

	localparam logic [DATA_W-1:0] MAX_TYPE = 32'd2;

endpackage

// ===== sv/packet_filter_priority_router_unit.sv =====
// Output: a result goes from the input register straight into the output register, and is
// held back only while a stalled result holds the output register.
// Throughput: one item per cycle unless the output stalls; the input register feeds the checksum,
// filter and queue update logic, and the queue store read for the next item is issued as it is
// accepted. Reset: asynchronous, clears packet state, empties all queues and loads the register
// reset values; queue storage is not cleared and needs no sweep. Depends on pfr_pkg, pfr_queue_mem.
module packet_filter_priority_router_unit #(
	parameter int PACKET_WORDS = 16,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfr_pkg::DATA_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [pfr_pkg::DATA_W-1:0]     word,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfr_pkg::STATUS_W-1:0]   status,
	output logic [pfr_pkg::PORT_W-1:0]     port,
	output logic [pfr_pkg::DATA_W-1:0]     src_addr,
	output logic [pfr_pkg::DATA_W-1:0]     dst_addr,
	output logic [pfr_pkg::QSEL_W-1:0]     prio
);
	import pfr_pkg::*;

	localparam int IDX_W   = $clog2(PACKET_WORDS);
	localparam int SUM_W   = $clog2(2 * PACKET_WORDS * 65535 + 1);
	localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ENTRY_W = 2 * DATA_W;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PACKET_WORDS - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
	localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(QUEUE_DEPTH);

	logic [DATA_W-1:0] reject_src_low_q, reject_src_high_q;
	logic [DATA_W-1:0] port1_dst_high_q, port2_dst_high_q, port3_dst_high_q;

	logic              valid_s1, mode_s1, last_s1;
	logic [DATA_W-1:0] word_s1;

	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] hdr_src_q, hdr_dst_q, hdr_type_q;
	logic [SLOT_W-1:0] head_q [NUM_QUEUES];
	logic [FILL_W-1:0] fill_q [NUM_QUEUES];

	logic              out_valid_q;
	status_t           status_q;
	logic [PORT_W-1:0] port_q;
	logic [DATA_W-1:0] src_q, dst_q;
	logic [QSEL_W-1:0] prio_q;

	logic              s1_go;
	logic [SUM_W-1:0]  sum_nxt;
	logic [16:0]       fold1;
	logic [15:0]       fold2;
	logic              pkt_end;
	logic [DATA_W-1:0] src_e, dst_e, type_e;
	logic              bad_src, bad_sum, bad_type, full;
	logic [QSEL_W-1:0] enq_q;
	logic [SLOT_W-1:0] enq_slot;
	logic [SLOT_W:0]   slot_sum;
	logic              enqueue;
	logic              fwd_hit;
	logic [QSEL_W-1:0] fwd_q;
	logic              pop;
	logic [SLOT_W-1:0] head_n [NUM_QUEUES];
	logic [FILL_W-1:0] fill_n [NUM_QUEUES];
	logic [QSEL_W-1:0] rd_q;
	logic [SLOT_W-1:0] rd_head;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [DATA_W-1:0] fwd_src, fwd_dst;
	logic [PORT_W-1:0] fwd_port;

	logic              res_valid;
	status_t           res_status;
	logic [PORT_W-1:0] res_port;
	logic [DATA_W-1:0] res_src, res_dst;
	logic [QSEL_W-1:0] res_prio;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_src_low_q  <= RST_REJECT_SRC_LOW;
			reject_src_high_q <= RST_REJECT_SRC_HIGH;
			port1_dst_high_q  <= RST_PORT1_DST_HIGH;
			port2_dst_high_q  <= RST_PORT2_DST_HIGH;
			port3_dst_high_q  <= RST_PORT3_DST_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REJECT_SRC_LOW:  reject_src_low_q  <= cfg_data;
				CFG_REJECT_SRC_HIGH: reject_src_high_q <= cfg_data;
				CFG_PORT1_DST_HIGH:  port1_dst_high_q  <= cfg_data;
				CFG_PORT2_DST_HIGH:  port2_dst_high_q  <= cfg_data;
				CFG_PORT3_DST_HIGH:  port3_dst_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s1_go    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			word_s1 <= word;
			last_s1 <= last;
		end
	end

	always_comb begin
		sum_nxt = sum_q + SUM_W'(word_s1[15:0]) + SUM_W'(word_s1[31:16]);
		fold1   = 17'(sum_nxt[15:0]) + 17'(sum_nxt[SUM_W-1:16]);
		fold2   = fold1[15:0] + 16'(fold1[16]);
		pkt_end = !mode_s1 && (last_s1 || (idx_q == LAST_IDX));
		src_e   = (idx_q == IDX_W'(0)) ? word_s1 : hdr_src_q;
		dst_e   = (idx_q == IDX_W'(1)) ? word_s1 : hdr_dst_q;
		type_e  = (idx_q == IDX_W'(2)) ? word_s1 : hdr_type_q;

		bad_src  = (reject_src_low_q <= src_e) && (src_e <= reject_src_high_q);
		bad_sum  = (~fold2) != 16'd0;
		bad_type = type_e > MAX_TYPE;
		enq_q    = type_e[QSEL_W-1:0];

		full     = 1'b0;
		slot_sum = '0;
		for (int q = 0; q < NUM_QUEUES; q++) begin
			if (enq_q == QSEL_W'(q)) begin
				full     = fill_q[q] == FULL_FILL;
				slot_sum = (SLOT_W + 1)'(head_q[q]) + (SLOT_W + 1)'(fill_q[q]);
			end
		end
		if (slot_sum >= DEPTH_EXT) begin
			enq_slot = SLOT_W'(slot_sum - DEPTH_EXT);
		end else begin
			enq_slot = SLOT_W'(slot_sum);
		end
		enqueue = s1_go && pkt_end && !bad_src && !bad_sum && !bad_type && !full;

		fwd_hit = 1'b0;
		fwd_q   = '0;
		for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
			if (fill_q[q] != '0) begin
				fwd_hit = 1'b1;
				fwd_q   = QSEL_W'(q);
			end
		end
		pop = s1_go && mode_s1 && fwd_hit;

		for (int q = 0; q < NUM_QUEUES; q++) begin
			head_n[q] = head_q[q];
			fill_n[q] = fill_q[q];
			if (enqueue && (enq_q == QSEL_W'(q))) begin
				fill_n[q] = fill_q[q] + FILL_W'(1);
			end
			if (pop && (fwd_q == QSEL_W'(q))) begin
				fill_n[q] = fill_q[q] - FILL_W'(1);
				head_n[q] = (head_q[q] == LAST_SLOT) ? '0 : head_q[q] + SLOT_W'(1);
			end
		end

		rd_q    = '0;
		rd_head = head_n[0];
		for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
			if (fill_n[q] != '0) begin
				rd_q    = QSEL_W'(q);
				rd_head = head_n[q];
			end
		end
		rd_addr = ADDR_W'(rd_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_head);
		wr_addr = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(enq_slot);
	end

	pfr_queue_mem #(
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W),
		.ENTRY_W (ENTRY_W)
	) u_queue_mem (
		.clk     (clk),
		.wr_en   (enqueue),
		.wr_addr (wr_addr),
		.wr_data ({src_e, dst_e}),
		.rd_en   (in_ready),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		fwd_src = rd_data[ENTRY_W-1:DATA_W];
		fwd_dst = rd_data[DATA_W-1:0];
		if (fwd_dst <= port1_dst_high_q) begin
			fwd_port = 2'd0;
		end else if (fwd_dst <= port2_dst_high_q) begin
			fwd_port = 2'd1;
		end else if (fwd_dst <= port3_dst_high_q) begin
			fwd_port = 2'd2;
		end else begin
			fwd_port = 2'd3;
		end

		res_valid  = mode_s1 || pkt_end;
		res_status = ST_EMPTY;
		res_port   = '0;
		res_src    = src_e;
		res_dst    = dst_e;
		res_prio   = '0;
		if (mode_s1) begin
			if (fwd_hit) begin
				res_status = ST_FORWARD;
				res_port   = fwd_port;
				res_src    = fwd_src;
				res_dst    = fwd_dst;
				res_prio   = fwd_q;
			end else begin
				res_src = '0;
				res_dst = '0;
			end
		end else if (bad_src) begin
			res_status = ST_BAD_SRC;
		end else if (bad_sum) begin
			res_status = ST_BAD_SUM;
		end else if (bad_type) begin
			res_status = ST_BAD_TYPE;
		end else if (full) begin
			res_status = ST_FULL;
			res_prio   = enq_q;
		end else begin
			res_status = status_t'(STATUS_W'(enq_q));
			res_prio   = enq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			sum_q      <= '0;
			hdr_src_q  <= '0;
			hdr_dst_q  <= '0;
			hdr_type_q <= '0;
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_q[q] <= '0;
				fill_q[q] <= '0;
			end
		end else if (s1_go) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_q[q] <= head_n[q];
				fill_q[q] <= fill_n[q];
			end
			if (pkt_end) begin
				idx_q      <= '0;
				sum_q      <= '0;
				hdr_src_q  <= '0;
				hdr_dst_q  <= '0;
				hdr_type_q <= '0;
			end else if (!mode_s1) begin
				idx_q      <= idx_q + IDX_W'(1);
				sum_q      <= sum_nxt;
				hdr_src_q  <= src_e;
				hdr_dst_q  <= dst_e;
				hdr_type_q <= type_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			status_q <= res_status;
			port_q   <= res_port;
			src_q    <= res_src;
			dst_q    <= res_dst;
			prio_q   <= res_prio;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign port      = port_q;
	assign src_addr  = src_q;
	assign dst_addr  = dst_q;
	assign prio      = prio_q;

endmodule

// ===== sv/pfr_queue_mem.sv =====
// Entry store for the three priority queues: one write port, one read port
// with registered read data and write-to-read bypass. No dependencies.
module pfr_queue_mem #(
	parameter int ENTRIES = 12,
	parameter int ADDR_W  = 4,
	parameter int ENTRY_W = 64
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

// ===== sv/pfr_checker.sv =====
// Port-level checks for the packet filter and priority router, and the bind
// that attaches them to the top level. Depends on pfr_pkg.
module pfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pfr_pkg::STATUS_W-1:0]  status,
	input logic [pfr_pkg::PORT_W-1:0]    port,
	input logic [pfr_pkg::DATA_W-1:0]    src_addr,
	input logic [pfr_pkg::DATA_W-1:0]    dst_addr,
	input logic [pfr_pkg::QSEL_W-1:0]    prio
);
	import pfr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(src_addr)
			&& $stable(dst_addr) && $stable(port) && $stable(prio))
		else $error("result changed during a stalled transfer");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |->
			(src_addr == '0) && (dst_addr == '0) && (port == '0) && (prio == '0))
		else $error("empty forward carries nonzero fields");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_BAD_SRC) || (status == ST_BAD_SUM)
			|| (status == ST_BAD_TYPE)) |-> (port == '0) && (prio == '0))
		else $error("rejected packet carries port or priority");

	a_queued_prio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_HIGH) || (status == ST_MEDIUM) || (status == ST_LOW))
			|-> (STATUS_W'(prio) == status) && (port == '0))
		else $error("queued status disagrees with priority");

endmodule

bind packet_filter_priority_router_unit pfr_checker u_pfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.port      (port),
	.src_addr  (src_addr),
	.dst_addr  (dst_addr),
	.prio      (prio)
);

// ===== sim/packet_filter_priority_router_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for packet_filter_priority_router_unit: a directed table, then random packets and
// forward requests under several register settings, each result scored against a predictor or a fixed table outcome.
// Depends on pfr_pkg and the RTL of the block; reads and writes no files.
module packet_filter_priority_router_unit_tb;
	import pfr_pkg::*;

	localparam int PACKET_WORDS   = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES     = 6;
	localparam int DIRECTED_ROWS  = 24;

	localparam int READY_ALWAYS   = 0;
	localparam int READY_COIN     = 1;
	localparam int READY_SPARSE   = 2;
	localparam int READY_PERIODIC = 3;
	localparam int READY_STYLES   = 4;

	localparam logic MODE_WORD    = 1'b0;
	localparam logic MODE_FORWARD = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
	localparam logic [DATA_W-1:0]    ALL_ONES         = '1;

	typedef struct packed {
		status_t             status;
		logic [PORT_W-1:0]   port;
		logic [DATA_W-1:0]   src;
		logic [DATA_W-1:0]   dst;
		logic [QSEL_W-1:0]   prio;
	} outcome_t;

	typedef struct packed {
		logic                mode;
		logic [DATA_W-1:0]   word;
		logic                last;
		logic                fixed;
		outcome_t            fixed_out;
	} stream_item_t;

	localparam outcome_t NO_OUTCOME = '{ST_EMPTY, '0, '0, '0, '0};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [DATA_W-1:0]    word;
	logic                 last;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [PORT_W-1:0]    port;
	logic [DATA_W-1:0]    src_addr;
	logic [DATA_W-1:0]    dst_addr;
	logic [QSEL_W-1:0]    prio;

	// predictor copy of registers and router state
	logic [DATA_W-1:0] win_lo = RST_REJECT_SRC_LOW;
	logic [DATA_W-1:0] win_hi = RST_REJECT_SRC_HIGH;
	logic [DATA_W-1:0] bound1 = RST_PORT1_DST_HIGH;
	logic [DATA_W-1:0] bound2 = RST_PORT2_DST_HIGH;
	logic [DATA_W-1:0] bound3 = RST_PORT3_DST_HIGH;
	int unsigned       pkt_pos = 0;
	logic [31:0]       pkt_sum = '0;
	logic [DATA_W-1:0] pkt_src = '0;
	logic [DATA_W-1:0] pkt_dst = '0;
	logic [DATA_W-1:0] pkt_type = '0;
	logic [DATA_W-1:0] fifo_src [NUM_QUEUES][QUEUE_DEPTH];
	logic [DATA_W-1:0] fifo_dst [NUM_QUEUES][QUEUE_DEPTH];
	int unsigned       fifo_head [NUM_QUEUES] = '{default: 0};
	int unsigned       fifo_count [NUM_QUEUES] = '{default: 0};

	outcome_t     pending_outcomes[$];
	stream_item_t word_stream[$];
	stream_item_t cur_item;
	int           errors = 0;
	int unsigned  hold_requests = 0;
	int unsigned  hold_served = 0;
	int unsigned  ready_style = READY_ALWAYS;
	int unsigned  idle_cycles = 0;
	int           phase_items [NUM_PHASES] = '{176, 170, 170, 170, 170, 70};

	stream_item_t directed_table [DIRECTED_ROWS] = '{
		'{MODE_FORWARD, 32'h0000_0000, 1'b0, 1'b1, '{ST_EMPTY, 2'd0, 32'h0, 32'h0, 2'd0}},
		'{MODE_WORD, 32'h0000_0000, 1'b1, 1'b1, '{ST_BAD_SUM, 2'd0, 32'h0, 32'h0, 2'd0}},
		'{MODE_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1, '{ST_HIGH, 2'd0, 32'hFFFF_FFFF, 32'h0, 2'd0}},
		'{MODE_WORD, RST_REJECT_SRC_LOW, 1'b1, 1'b1,
			'{ST_BAD_SRC, 2'd0, RST_REJECT_SRC_LOW, 32'h0, 2'd0}},
		'{MODE_WORD, RST_REJECT_SRC_HIGH, 1'b1, 1'b1,
			'{ST_BAD_SRC, 2'd0, RST_REJECT_SRC_HIGH, 32'h0, 2'd0}},
		'{MODE_FORWARD, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{ST_FORWARD, 2'd0, 32'hFFFF_FFFF, 32'h0, 2'd0}},
		'{MODE_WORD, 32'h0000_FFFC, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'h0000_0003, 1'b1, 1'b1,
			'{ST_BAD_TYPE, 2'd0, 32'h0000_FFFC, 32'h0, 2'd0}},
		'{MODE_WORD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1, '{ST_BAD_TYPE, 2'd0, 32'h0, 32'h0, 2'd0}},
		'{MODE_WORD, 32'hFFFD_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_FORWARD, 32'h1234_5678, 1'b0, 1'b1, '{ST_EMPTY, 2'd0, 32'h0, 32'h0, 2'd0}},
		'{MODE_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'h0000_0002, 1'b1, 1'b0, NO_OUTCOME},
		'{MODE_FORWARD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_0000, 1'b1, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_0000, 1'b1, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_0000, 1'b1, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_0000, 1'b1, 1'b0, NO_OUTCOME},
		'{MODE_WORD, 32'hFFFF_0000, 1'b1, 1'b1,
			'{ST_FULL, 2'd0, 32'hFFFF_0000, 32'h0, 2'd0}},
		'{MODE_FORWARD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME},
		'{MODE_FORWARD, 32'h0000_0000, 1'b0, 1'b0, NO_OUTCOME}
	};

	packet_filter_priority_router_unit #(
		.PACKET_WORDS(PACKET_WORDS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) DUT (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [15:0] fold_sum(input logic [31:0] sum);
		logic [31:0] s;
		s = {16'd0, sum[15:0]} + (sum >> 16);
		s = s + (s >> 16);
		return s[15:0];
	endfunction

	function automatic logic [PORT_W-1:0] pick_port(input logic [DATA_W-1:0] dst);
		if (dst <= bound1)
			return 2'd0;
		if (dst <= bound2)
			return 2'd1;
		if (dst <= bound3)
			return 2'd2;
		return 2'd3;
	endfunction

	task automatic compute_outcome(input logic m, input logic [DATA_W-1:0] w, input logic l,
			output bit produced, output outcome_t res);
		bit          found;
		int unsigned q;
		int unsigned slot;
		produced = 1'b0;
		found = 1'b0;
		res = NO_OUTCOME;
		if (m == MODE_FORWARD) begin
			produced = 1'b1;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (!found && fifo_count[i] != 0) begin
					found = 1'b1;
					slot = fifo_head[i];
					res.status = ST_FORWARD;
					res.port = pick_port(fifo_dst[i][slot]);
					res.src = fifo_src[i][slot];
					res.dst = fifo_dst[i][slot];
					res.prio = QSEL_W'(i);
					fifo_head[i] = (slot + 1) % QUEUE_DEPTH;
					fifo_count[i]--;
				end
			end
			return;
		end
		pkt_sum = pkt_sum + {16'd0, w[15:0]} + (w >> 16);
		case (pkt_pos)
			0: pkt_src = w;
			1: pkt_dst = w;
			2: pkt_type = w;
			default: ;
		endcase
		if (l || pkt_pos >= PACKET_WORDS - 1) begin
			produced = 1'b1;
			res.src = pkt_src;
			res.dst = pkt_dst;
			if (win_lo <= pkt_src && pkt_src <= win_hi) begin
				res.status = ST_BAD_SRC;
			end else if (~fold_sum(pkt_sum) != 16'd0) begin
				res.status = ST_BAD_SUM;
			end else if (pkt_type > MAX_TYPE) begin
				res.status = ST_BAD_TYPE;
			end else begin
				q = pkt_type;
				res.prio = QSEL_W'(q);
				if (fifo_count[q] >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slot = (fifo_head[q] + fifo_count[q]) % QUEUE_DEPTH;
					fifo_src[q][slot] = pkt_src;
					fifo_dst[q][slot] = pkt_dst;
					fifo_count[q]++;
					res.status = status_t'(q);
				end
			end
			pkt_pos = 0;
			pkt_sum = '0;
			pkt_src = '0;
			pkt_dst = '0;
			pkt_type = '0;
		end else begin
			pkt_pos++;
		end
	endtask

	task automatic report_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin : score
		bit       produced;
		outcome_t res;
		outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_outcomes.size() == 0) begin
					report_error($sformatf("result with status %0d and nothing pending", status));
				end else begin
					want = pending_outcomes.pop_front();
					check_field("status", DATA_W'(status), DATA_W'(want.status));
					check_field("port", DATA_W'(port), DATA_W'(want.port));
					check_field("src_addr", src_addr, want.src);
					check_field("dst_addr", dst_addr, want.dst);
					check_field("prio", DATA_W'(prio), DATA_W'(want.prio));
				end
			end
			if (in_valid && in_ready) begin
				compute_outcome(mode, word, last, produced, res);
				if (produced)
					pending_outcomes.push_back(cur_item.fixed ? cur_item.fixed_out : res);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_REJECT_SRC_LOW: win_lo = cfg_data;
					CFG_REJECT_SRC_HIGH: win_hi = cfg_data;
					CFG_PORT1_DST_HIGH: bound1 = cfg_data;
					CFG_PORT2_DST_HIGH: bound2 = cfg_data;
					CFG_PORT3_DST_HIGH: bound3 = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : receiver
		int unsigned hold_left;
		int unsigned tick;
		hold_left = 0;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (ready_style)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN: out_ready <= 1'($urandom_range(1, 0));
					READY_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
					default: out_ready <= (tick % 5 < 2);
				endcase
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_src();
		logic [DATA_W-1:0] s;
		s = $urandom;
		for (int i = 0; i < 8; i++) begin
			s = $urandom;
			if ($urandom_range(3, 0) == 0)
				s = $urandom_range(1, 0) ? win_lo - 1 : win_hi + 1;
			if (!(win_lo <= s && s <= win_hi))
				return s;
		end
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] pick_dst();
		case ($urandom_range(5, 0))
			0: return bound1 + $urandom_range(2, 0) - 1;
			1: return bound2 + $urandom_range(2, 0) - 1;
			2: return bound3 + $urandom_range(2, 0) - 1;
			3: return $urandom_range(1, 0) ? ALL_ONES : '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_word(input logic [DATA_W-1:0] w, input logic l);
		word_stream.push_back('{MODE_WORD, w, l, 1'b0, NO_OUTCOME});
	endtask

	task automatic add_forward();
		word_stream.push_back('{MODE_FORWARD, DATA_W'($urandom), 1'($urandom_range(1, 0)),
			1'b0, NO_OUTCOME});
	endtask

	// good packets carry a valid checksum, a known type and a source that pick_src tries to place outside the window
	task automatic add_packet(input bit good);
		logic [DATA_W-1:0] pkt [PACKET_WORDS];
		logic [31:0]       sum;
		int                len;
		int                fwd_at;
		bit                overlong;
		len = ($urandom_range(3, 0) == 0) ? $urandom_range(PACKET_WORDS - 1, 4) : PACKET_WORDS;
		overlong = (len == PACKET_WORDS) && ($urandom_range(4, 0) == 0);
		fwd_at = ($urandom_range(5, 0) == 0) ? $urandom_range(len - 1, 1) : -1;
		for (int i = 0; i < PACKET_WORDS; i++)
			pkt[i] = $urandom;
		pkt[1] = pick_dst();
		if (good || $urandom_range(1, 0)) begin
			pkt[0] = pick_src();
			pkt[2] = $urandom_range(MAX_TYPE, 0);
		end else begin
			case ($urandom_range(2, 0))
				0: pkt[0] = win_lo;
				1: pkt[0] = win_hi;
				default: pkt[0] = $urandom;
			endcase
			pkt[2] = $urandom_range(1, 0) ? DATA_W'($urandom) : MAX_TYPE + 1;
		end
		pkt[3][15:0] = '0;
		sum = '0;
		for (int i = 0; i < len; i++)
			sum = sum + {16'd0, pkt[i][15:0]} + (pkt[i] >> 16);
		pkt[3][15:0] = ~fold_sum(sum);
		if (!good && $urandom_range(1, 0))
			pkt[$urandom_range(len - 1, 3)] ^= DATA_W'(1) << $urandom_range(DATA_W - 1, 0);
		for (int i = 0; i < len; i++) begin
			if (i == fwd_at)
				add_forward();
			push_word(pkt[i], (i == len - 1) && !overlong);
		end
	endtask

	task automatic add_noise();
		int n;
		n = $urandom_range(3, 1);
		for (int i = 0; i < n; i++)
			push_word($urandom, (i == n - 1) ? ($urandom_range(3, 0) != 0)
				: 1'($urandom_range(1, 0)));
	endtask

	task automatic build_random(input int budget);
		int start;
		start = word_stream.size();
		while (word_stream.size() - start < budget) begin
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4, 5: add_packet(1'b1);
				6: add_packet(1'b0);
				7, 8: repeat ($urandom_range(4, 1)) add_forward();
				default: add_noise();
			endcase
		end
	endtask

	task automatic drive_items(input int hold_at, input int pause_at);
		stream_item_t nxt;
		int           burst_left;
		int           n;
		n = 0;
		burst_left = $urandom_range(40, 1);
		while (word_stream.size() != 0) begin
			if (n == pause_at) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending_outcomes.size() != 0)
					@(negedge clk);
			end
			if (n == hold_at)
				hold_requests++;
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 1);
				if ($urandom_range(2, 0) != 0) begin
					repeat ($urandom_range(12, 1)) begin
						@(negedge clk);
						in_valid <= 1'b0;
					end
				end
			end
			nxt = word_stream.pop_front();
			@(negedge clk);
			cur_item = nxt;
			in_valid <= 1'b1;
			mode <= nxt.mode;
			word <= nxt.word;
			last <= nxt.last;
			do @(posedge clk); while (!in_ready);
			burst_left--;
			n++;
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input int ph);
		logic [DATA_W-1:0] lo, hi, b1, b2, b3, t;
		lo = $urandom;
		hi = $urandom;
		b1 = $urandom;
		b2 = $urandom;
		b3 = $urandom;
		case (ph)
			1: ;
			2: begin
				lo = '0;
				hi = '0;
				b1 = '0;
				b2 = '0;
				b3 = ALL_ONES;
			end
			3: begin
				lo = ALL_ONES;
				hi = '0;
				b1 = ALL_ONES;
				b2 = '0;
				b3 = '0;
			end
			default: begin
				if (b1 > b2) begin t = b1; b1 = b2; b2 = t; end
				if (b2 > b3) begin t = b2; b2 = b3; b3 = t; end
				if (b1 > b2) begin t = b1; b1 = b2; b2 = t; end
				lo = (ph == NUM_PHASES - 1) ? '0 : ALL_ONES;
				hi = ALL_ONES;
			end
		endcase
		write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)), $urandom);
		write_reg(CFG_REJECT_SRC_LOW, lo);
		write_reg(CFG_REJECT_SRC_HIGH, hi);
		write_reg(CFG_PORT1_DST_HIGH, b1);
		write_reg(CFG_PORT2_DST_HIGH, b2);
		write_reg(CFG_PORT3_DST_HIGH, b3);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_REJECT_SRC_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_WORD;
		word = '0;
		last = 1'b0;
		cur_item = '{MODE_WORD, '0, 1'b0, 1'b0, NO_OUTCOME};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_idle();
				apply_setting(ph);
			end
			ready_style = ph % READY_STYLES;
			if (ph == 0)
				foreach (directed_table[i])
					word_stream.push_back(directed_table[i]);
			build_random(phase_items[ph]);
			drive_items(word_stream.size() / 4, (word_stream.size() * 3) / 4);
		end
		wait_idle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
